/* rtl/mdm_pkg.sv */
// Package with shared types, codes and frame constants for the MDIO management master.
`timescale 1ns / 1ps
`default_nettype none

package mdm_pkg;

   localparam int MDM_PREAMBLE_BITS = 33;

   localparam int REG_ADDR_W   = 5;
   localparam int PHY_ADDR_W   = 5;
   localparam int DATA_W       = 16;
   localparam int CMD_W        = 32;
   localparam int SAMPLE_W     = 19;

   localparam int READ_CMD_BITS      = 16;
   localparam int WRITE_CMD_BITS     = 32;
   localparam int READ_SAMPLE_BITS   = 19;
   localparam int WRITE_RELEASE_BITS = 2;

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 24;

   typedef enum logic [1:0] {
      OP_BIT   = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'b0001,
      PH_PREAMBLE = 4'b0010,
      PH_COMMAND  = 4'b0100,
      PH_RELEASE  = 4'b1000
   } phase_type;

   typedef struct packed {
      op_type                  operation;
      logic [REG_ADDR_W-1:0]   reg_addr;
      logic [DATA_W-1:0]       write_data;
      logic                    mdio_in;
   } req_type;

   typedef struct packed {
      logic                    mdio_out;
      logic                    release_line;
      logic                    busy_res;
      logic                    frame_done;
      logic [DATA_W-1:0]       read_value;
      logic                    start_rejected;
   } rsp_type;

   // Read command, left aligned: two extra ones, start 01, opcode 10, addresses.
   function automatic logic [CMD_W-1:0] build_read_command(
      input logic [PHY_ADDR_W-1:0] phy,
      input logic [REG_ADDR_W-1:0] reg_a
   );
      return {2'b11, 2'b01, 2'b10, phy, reg_a, 16'h0000};
   endfunction

   // Write command: start 01, opcode 01, addresses, turnaround 10, data.
   function automatic logic [CMD_W-1:0] build_write_command(
      input logic [PHY_ADDR_W-1:0] phy,
      input logic [REG_ADDR_W-1:0] reg_a,
      input logic [DATA_W-1:0]     data
   );
      return {2'b01, 2'b01, phy, reg_a, 2'b10, data};
   endfunction

endpackage

`default_nettype wire

/* rtl/mdio_management_master.sv */
// Top level of the Clause 22 MDIO management master with its stream and CSR ports.
//
//  channel | direction | handshake              | contents
//  req     | in        | req_tvalid/req_tready  | one MDC bit period: operation, register address, write data, sample
//  rsp     | out       | rsp_tvalid/rsp_tready  | line drive, status, read data; tlast ends a frame
//  csr     | in        | csr_valid/csr_ready    | PHY address register
//
// Each accepted word is one bit period and gives one result word: it is held in the input
// register, then passes through the frame sequencer into the output register. Both stages
// advance together, so a word can enter every cycle while the rsp side takes results.
// Reset is synchronous; it clears the frame state, the PHY address and both stage valids.
// A stalled rsp side holds the output register and backs up into the input register.
`timescale 1ns / 1ps
`default_nettype none

module mdio_management_master
   import mdm_pkg::*;
#(
   parameter int PREAMBLE_BITS = MDM_PREAMBLE_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // reg_addr [4:0], write_data [20:5], mdio_in [21], zero fill [23:22]
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // operation [1:0]
   input  wire logic [1:0]             req_tuser,

   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // mdio_out [0], release_line [1], busy_res [2], read_value [18:3],
   // start_rejected [19], zero fill [23:20]
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   // frame_done
   output logic                        rsp_tlast,

   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [PHY_ADDR_W-1:0]  csr_data
);

   logic                   in_valid_ff, in_valid_in;
   req_type                in_word_ff;
   logic                   out_valid_ff, out_valid_in;
   rsp_type                out_word_ff;
   logic [PHY_ADDR_W-1:0]  phy_addr_ff;

   logic                   advance;
   logic                   accept;
   req_type                req_word;
   rsp_type                rsp_word;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign req_word.operation  = op_type'(req_tuser);
   assign req_word.reg_addr   = req_tdata[4:0];
   assign req_word.write_data = req_tdata[20:5];
   assign req_word.mdio_in    = req_tdata[21];

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   mdm_frame #(
      .PREAMBLE_BITS (PREAMBLE_BITS)
   ) u_frame (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .phy_address (phy_addr_ff),
      .req         (in_word_ff),
      .rsp         (rsp_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phy_addr_ff  <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            phy_addr_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_word_ff <= req_word;
      end
      if (advance) begin
         out_word_ff <= rsp_word;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_word_ff.frame_done;
   assign rsp_tdata  = {4'b0000,
                        out_word_ff.start_rejected,
                        out_word_ff.read_value,
                        out_word_ff.busy_res,
                        out_word_ff.release_line,
                        out_word_ff.mdio_out};

`ifndef SYNTH
   // The end of a frame is always reported inside a frame.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[2])
      else $error("frame_done outside a frame");

   // Read data appears only on the last period of a frame.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[18:3] != 16'h0000) |-> rsp_tlast)
      else $error("read_value nonzero before frame end");

   // The master drives the line only while a frame is running.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[1] |-> rsp_tdata[2])
      else $error("line driven while idle");

   // A rejected start can only happen while a frame is in progress.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[19] |-> rsp_tdata[2])
      else $error("start rejected while idle");

   // A word held in the input register moves on as soon as the output side has room.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && (!out_valid_ff || rsp_tready) |=> out_valid_ff)
      else $error("input word did not advance");
`endif

endmodule

`default_nettype wire

/* rtl/mdm_frame.sv */
// Frame sequencer: phase, bit counter and shift registers, one bit period per enable.
`timescale 1ns / 1ps
`default_nettype none

module mdm_frame
   import mdm_pkg::*;
#(
   parameter int PREAMBLE_BITS = MDM_PREAMBLE_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic [PHY_ADDR_W-1:0] phy_address,
   input  wire req_type               req,
   output rsp_type                    rsp
);

   localparam int CNT_MAX = (PREAMBLE_BITS > WRITE_CMD_BITS) ? PREAMBLE_BITS : WRITE_CMD_BITS;
   localparam int CNT_W   = $clog2(CNT_MAX + 1);

   localparam logic [CNT_W-1:0] PRE_LIMIT    = CNT_W'(PREAMBLE_BITS);
   localparam logic [CNT_W-1:0] RD_CMD_LIMIT = CNT_W'(READ_CMD_BITS);
   localparam logic [CNT_W-1:0] WR_CMD_LIMIT = CNT_W'(WRITE_CMD_BITS);
   localparam logic [CNT_W-1:0] RD_REL_LIMIT = CNT_W'(READ_SAMPLE_BITS);
   localparam logic [CNT_W-1:0] WR_REL_LIMIT = CNT_W'(WRITE_RELEASE_BITS);

   phase_type            phase_ff, phase_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic [SAMPLE_W-1:0]  sample_ff, sample_in;
   logic                 is_read_ff, is_read_in;

   logic                 start;
   phase_type            phase_s;
   logic [CNT_W-1:0]     count_s;
   logic [CNT_W-1:0]     count_inc;
   logic [CMD_W-1:0]     cmd_s;
   logic [SAMPLE_W-1:0]  sample_s;
   logic                 is_read_s;

   assign start = (req.operation == OP_READ) || (req.operation == OP_WRITE);

   // Apply an accepted start first; the same period then runs as the first preamble bit.
   always_comb begin
      phase_s   = phase_ff;
      count_s   = count_ff;
      cmd_s     = cmd_ff;
      sample_s  = sample_ff;
      is_read_s = is_read_ff;
      rsp       = '0;
      rsp.release_line = 1'b1;

      if (start && phase_ff == PH_IDLE) begin
         is_read_s = (req.operation == OP_READ);
         cmd_s     = is_read_s ? build_read_command(phy_address, req.reg_addr)
                               : build_write_command(phy_address, req.reg_addr, req.write_data);
         sample_s  = '0;
         count_s   = '0;
         phase_s   = PH_PREAMBLE;
      end else if (start) begin
         rsp.start_rejected = 1'b1;
      end

      count_inc = count_s + 1'b1;

      phase_in   = phase_s;
      count_in   = count_s;
      cmd_in     = cmd_s;
      sample_in  = sample_s;
      is_read_in = is_read_s;

      unique case (phase_s)
         PH_IDLE: begin
         end
         PH_PREAMBLE: begin
            rsp.busy_res     = 1'b1;
            rsp.mdio_out     = 1'b1;
            rsp.release_line = 1'b0;
            count_in         = count_inc;
            if (count_inc >= PRE_LIMIT) begin
               phase_in = PH_COMMAND;
               count_in = '0;
            end
         end
         PH_COMMAND: begin
            rsp.busy_res     = 1'b1;
            rsp.mdio_out     = cmd_s[CMD_W-1];
            rsp.release_line = 1'b0;
            cmd_in           = {cmd_s[CMD_W-2:0], 1'b0};
            count_in         = count_inc;
            if (count_inc >= (is_read_s ? RD_CMD_LIMIT : WR_CMD_LIMIT)) begin
               phase_in = PH_RELEASE;
               count_in = '0;
            end
         end
         PH_RELEASE: begin
            rsp.busy_res = 1'b1;
            count_in     = count_inc;
            if (is_read_s) begin
               sample_in = {sample_s[SAMPLE_W-2:0], req.mdio_in};
            end
            if (count_inc >= (is_read_s ? RD_REL_LIMIT : WR_REL_LIMIT)) begin
               rsp.frame_done = 1'b1;
               if (is_read_s) begin
                  // Drop the final idle sample; the turnaround samples fall off the top.
                  rsp.read_value = sample_in[DATA_W:1];
               end
               phase_in = PH_IDLE;
               count_in = '0;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            count_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         count_ff   <= '0;
         cmd_ff     <= '0;
         sample_ff  <= '0;
         is_read_ff <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         cmd_ff     <= cmd_in;
         sample_ff  <= sample_in;
         is_read_ff <= is_read_in;
      end
   end

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench for the Clause 22 MDIO management master.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
   import mdm_pkg::*;

   localparam int PREAMBLE_BITS   = MDM_PREAMBLE_BITS;
   localparam int READ_FRAME_LEN  = PREAMBLE_BITS + READ_CMD_BITS + READ_SAMPLE_BITS;
   localparam int WRITE_FRAME_LEN = PREAMBLE_BITS + WRITE_CMD_BITS + WRITE_RELEASE_BITS;
   localparam int RANDOM_ITEMS    = 330;
   localparam int RSP_HOLD_CYCLES = 150;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int MAX_SHOWN       = 10;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [1:0]             req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [PHY_ADDR_W-1:0]  csr_data;

   // Shadow of the frame sequencer, advanced once per accepted word.
   logic [PHY_ADDR_W-1:0]  phy_cfg = '0;
   phase_type              frame_ph = PH_IDLE;
   logic [6:0]             period_cnt = '0;
   logic [CMD_W-1:0]       cmd_bits = '0;
   logic [SAMPLE_W-1:0]    line_samples = '0;
   logic                   reading = 1'b0;

   rsp_type                bit_period_q[$];

   int mismatches = 0;
   int words_checked = 0;
   int items_sent = 0;
   int reads_done = 0;
   int writes_done = 0;
   int starts_rejected = 0;
   int phy_writes = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_cycles = 0;
   int hold_left = 0;
   bit rsp_hold_go = 1'b0;

   mdio_management_master dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // One MDC bit period of the management master.
   function automatic rsp_type mdio_bit_period(input req_type w);
      rsp_type r;
      logic    start;
      r = '0;
      r.release_line = 1'b1;
      start = (w.operation == OP_READ) || (w.operation == OP_WRITE);
      if (start && frame_ph == PH_IDLE) begin
         reading = (w.operation == OP_READ);
         if (reading) begin
            cmd_bits = {2'b11, 2'b01, 2'b10, phy_cfg, w.reg_addr, 16'h0000};
         end else begin
            cmd_bits = {2'b01, 2'b01, phy_cfg, w.reg_addr, 2'b10, w.write_data};
         end
         line_samples = '0;
         period_cnt = '0;
         frame_ph = PH_PREAMBLE;
      end else if (start) begin
         r.start_rejected = 1'b1;
         starts_rejected++;
      end
      if (frame_ph != PH_IDLE) begin
         r.busy_res = 1'b1;
         period_cnt = period_cnt + 7'd1;
         case (frame_ph)
            PH_PREAMBLE: begin
               r.mdio_out = 1'b1;
               r.release_line = 1'b0;
               if (period_cnt >= PREAMBLE_BITS) begin
                  frame_ph = PH_COMMAND;
                  period_cnt = '0;
               end
            end
            PH_COMMAND: begin
               r.mdio_out = cmd_bits[CMD_W-1];
               r.release_line = 1'b0;
               cmd_bits = cmd_bits << 1;
               if (period_cnt >= (reading ? READ_CMD_BITS : WRITE_CMD_BITS)) begin
                  frame_ph = PH_RELEASE;
                  period_cnt = '0;
               end
            end
            default: begin
               if (reading) begin
                  line_samples = {line_samples[SAMPLE_W-2:0], w.mdio_in};
               end
               if (period_cnt >= (reading ? READ_SAMPLE_BITS : WRITE_RELEASE_BITS)) begin
                  r.frame_done = 1'b1;
                  // Drop the two turnaround samples and the trailing idle sample.
                  if (reading) begin
                     r.read_value = line_samples[DATA_W:1];
                     reads_done++;
                  end else begin
                     writes_done++;
                  end
                  frame_ph = PH_IDLE;
                  period_cnt = '0;
               end
            end
         endcase
      end
      return r;
   endfunction

   // Predicts on every accepted input word and checks every accepted result word.
   always @(posedge clock) begin : scoreboard
      req_type w;
      rsp_type got;
      rsp_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            phy_cfg = csr_data;
            phy_writes++;
         end
         if (req_tvalid && req_tready) begin
            w.operation  = op_type'(req_tuser);
            w.reg_addr   = req_tdata[4:0];
            w.write_data = req_tdata[20:5];
            w.mdio_in    = req_tdata[21];
            bit_period_q.push_back(mdio_bit_period(w));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.mdio_out       = rsp_tdata[0];
            got.release_line   = rsp_tdata[1];
            got.busy_res       = rsp_tdata[2];
            got.read_value     = rsp_tdata[18:3];
            got.start_rejected = rsp_tdata[19];
            got.frame_done     = rsp_tlast;
            words_checked++;
            if (bit_period_q.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN) begin
                  $display("%0t: result word with nothing pending: out=%b rel=%b busy=%b",
                           $realtime, got.mdio_out, got.release_line, got.busy_res);
               end
            end else begin
               want = bit_period_q.pop_front();
               if (got.mdio_out !== want.mdio_out
                   || got.release_line !== want.release_line
                   || got.busy_res !== want.busy_res
                   || got.frame_done !== want.frame_done
                   || got.read_value !== want.read_value
                   || got.start_rejected !== want.start_rejected) begin
                  mismatches++;
                  if (mismatches <= MAX_SHOWN) begin
                     $display("%0t: word %0d expected out=%b rel=%b busy=%b done=%b rd=%h rej=%b",
                              $realtime, words_checked, want.mdio_out, want.release_line,
                              want.busy_res, want.frame_done, want.read_value,
                              want.start_rejected);
                     $display("%0t: word %0d actual   out=%b rel=%b busy=%b done=%b rd=%h rej=%b",
                              $realtime, words_checked, got.mdio_out, got.release_line,
                              got.busy_res, got.frame_done, got.read_value,
                              got.start_rejected);
                  end
               end
            end
         end
      end
   end

   // Result side back pressure, with one long hold-off on request.
   always @(posedge clock) begin
      if (rsp_hold_go) begin
         rsp_hold_go = 1'b0;
         hold_left = RSP_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // Offers one bit period and returns at the edge where it is taken.
   task automatic send_bit(input op_type op, input logic [REG_ADDR_W-1:0] ra,
                           input logic [DATA_W-1:0] wd, input logic mi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, mi, wd, ra};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (bit_period_q.size() != 0) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_phy_address(input logic [PHY_ADDR_W-1:0] addr);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= addr;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // A whole frame; line_fill below zero gives a random MDIO line.
   task automatic run_frame(input op_type op, input logic [REG_ADDR_W-1:0] ra,
                            input logic [DATA_W-1:0] wd, input int line_fill,
                            input int noise_pct);
      int     len;
      int     k;
      op_type nop;
      logic   mi;
      len = (op == OP_READ) ? READ_FRAME_LEN : WRITE_FRAME_LEN;
      mi = (line_fill < 0) ? 1'($urandom_range(1)) : line_fill[0];
      send_bit(op, ra, wd, mi);
      for (k = 1; k < len; k++) begin
         nop = OP_BIT;
         if ($urandom_range(99) < noise_pct) begin
            nop = op_type'($urandom_range(1, 3));
         end
         mi = (line_fill < 0) ? 1'($urandom_range(1)) : line_fill[0];
         send_bit(nop, REG_ADDR_W'($urandom_range(31)), DATA_W'($urandom_range(65535)), mi);
      end
   endtask

   task automatic test_idle_periods();
      send_bit(OP_BIT, '0, '0, 1'b0);
      send_bit(OP_BIT, '1, '1, 1'b1);
      // The unused code is a plain period and never flagged.
      send_bit(OP_NONE, '0, '0, 1'b0);
      send_bit(OP_NONE, '1, '1, 1'b1);
   endtask

   task automatic test_read_frame();
      set_phy_address(5'h1F);
      run_frame(OP_READ, 5'h1F, 16'hFFFF, 1, 0);
   endtask

   task automatic test_write_frames();
      // Back to back, so the second start lands on the first idle period.
      run_frame(OP_WRITE, 5'h00, 16'hFFFF, 0, 0);
      run_frame(OP_WRITE, 5'h1F, 16'h0000, 1, 0);
   endtask

   task automatic test_busy_starts();
      int k;
      send_bit(OP_READ, 5'h0A, 16'h1234, 1'b0);
      send_bit(OP_WRITE, '1, '1, 1'b0);
      send_bit(OP_READ, '0, '0, 1'b0);
      send_bit(OP_NONE, '1, '1, 1'b0);
      // The frame in flight must keep the address it started with.
      set_phy_address(5'h00);
      for (k = 4; k < READ_FRAME_LEN - 1; k++) begin
         send_bit(OP_BIT, REG_ADDR_W'($urandom_range(31)), DATA_W'($urandom_range(65535)),
                  1'b0);
      end
      send_bit(OP_WRITE, 5'h15, 16'hA5A5, 1'b0);
   endtask

   task automatic test_random_traffic(input int target, input bit with_hold);
      int     stop_at;
      int     pick;
      int     n;
      op_type op;
      stop_at = items_sent + target;
      set_phy_address(PHY_ADDR_W'($urandom_range(31)));
      if (with_hold) begin
         @(negedge clock) rsp_hold_go = 1'b1;
         @(posedge clock);
      end
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            n = $urandom_range(1, 3);
            repeat (n) begin
               op = ($urandom_range(1) != 0) ? OP_NONE : OP_BIT;
               send_bit(op, REG_ADDR_W'($urandom_range(31)), DATA_W'($urandom_range(65535)),
                        1'($urandom_range(1)));
            end
         end else if (pick < 16) begin
            set_phy_address(PHY_ADDR_W'($urandom_range(31)));
         end else begin
            op = ($urandom_range(1) != 0) ? OP_READ : OP_WRITE;
            run_frame(op, REG_ADDR_W'($urandom_range(31)), DATA_W'($urandom_range(65535)),
                      -1, 4);
         end
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_BIT;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      send_idle_pct = 27;
      recv_idle_pct = 76;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_idle_periods();
      test_read_frame();
      test_write_frames();
      test_busy_starts();

      test_random_traffic(RANDOM_ITEMS / 3, 1'b0);
      send_idle_pct = 76;
      recv_idle_pct = 27;
      test_random_traffic(RANDOM_ITEMS / 3, 1'b0);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(RANDOM_ITEMS / 3, 1'b1);

      drain_results();
      repeat (10) @(posedge clock);
      if (bit_period_q.size() != 0) begin
         mismatches += bit_period_q.size();
      end
      $display("Sent %0d bit periods, checked %0d result words, %0d mismatches.",
               items_sent, words_checked, mismatches);
      $display("Frames: %0d reads, %0d writes; %0d starts refused; %0d PHY address writes.",
               reads_done, writes_done, starts_rejected, phy_writes);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

`default_nettype wire
